FILE: hdl/qbsr_pkg.sv
// Shared types, widths and arithmetic steps of the Bezier scanline root solver.
package qbsr_pkg;

	localparam int IN_W           = 16;
	localparam int OUT_W          = 24;
	localparam int ROOT_FRAC_BITS = 16;
	localparam int GUARD          = 8;

	// power-basis coefficient widths
	localparam int A_W = IN_W + 3;
	localparam int B_W = IN_W + 2;
	localparam int C_W = IN_W + 1;
	localparam int PROD_W = 2 * B_W;
	localparam int DFULL_W = PROD_W + 3;
	localparam int D_W = PROD_W + 1;

	// square root: one result bit per stage
	localparam int SQ_W     = D_W + 2 * GUARD + 1;
	localparam int SQ_STEPS = (D_W + 2 * GUARD + 1) / 2;
	localparam int S_W      = SQ_STEPS;

	// root division
	localparam int NP_W  = S_W + 1;
	localparam int UN_W  = NP_W;
	localparam int UD_W  = A_W + GUARD + 1;
	localparam int Q_W   = OUT_W;
	localparam int DIV_W = UD_W + Q_W;

	// curve evaluation
	localparam int P1_W    = A_W + OUT_W;
	localparam int INNER_W = 29;
	localparam int P2_W    = INNER_W + OUT_W;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NEG_DISC = 2'd1,
		ST_DEGEN    = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [A_W-1:0] ax;
		logic signed [A_W-1:0] ay;
		logic signed [B_W-1:0] bx;
		logic signed [B_W-1:0] by;
		logic signed [C_W-1:0] cx;
		logic signed [C_W-1:0] cy;
	} coef_t;

	typedef struct packed {
		coef_t           coef;
		logic [D_W-1:0]  d;
		status_t         status;
	} qentry_t;

	typedef struct packed {
		coef_t   coef;
		status_t status;
	} item_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] res;
	} sq_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [Q_W-1:0]   q;
		logic             neg;
		logic             ovf;
	} dv_t;

	// one step of the digit-by-digit square root, i counts from the top pair
	function automatic sq_t sq_step(sq_t st, int i);
		logic [SQ_W-1:0] bitv;
		logic [SQ_W-1:0] trial;
		sq_t r;
		bitv  = SQ_W'(1) << (2 * (SQ_STEPS - 1 - i));
		trial = st.res + bitv;
		if (st.rem >= trial) begin
			r.rem = st.rem - trial;
			r.res = (st.res >> 1) + bitv;
		end else begin
			r.rem = st.rem;
			r.res = st.res >> 1;
		end
		return r;
	endfunction

	// restoring division, one quotient bit
	function automatic dv_t div_step(dv_t st, logic [UD_W-1:0] ud, int b);
		logic [DIV_W-1:0] dsh;
		dv_t r;
		dsh = DIV_W'(ud) << b;
		r   = st;
		if (st.rem >= dsh) begin
			r.rem  = st.rem - dsh;
			r.q[b] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] root_sat(dv_t st);
		logic big;
		big = st.ovf || st.q[Q_W-1];
		if (!st.neg)
			return big ? OUT_MAX : $signed(st.q);
		else
			return big ? OUT_MIN : -$signed(st.q);
	endfunction

	function automatic logic signed [INNER_W-1:0] eval_inner(logic signed [B_W-1:0] b,
			logic signed [P1_W-1:0] p);
		logic signed [P1_W+1:0] s;
		s = ((P1_W+2)'(b) <<< ROOT_FRAC_BITS) + (P1_W+2)'(p)
			+ ((P1_W+2)'(1) <<< (ROOT_FRAC_BITS - 1));
		return INNER_W'(s >>> ROOT_FRAC_BITS);
	endfunction

	function automatic logic signed [OUT_W-1:0] eval_point(logic signed [C_W-1:0] c,
			logic signed [P2_W-1:0] p);
		logic signed [P2_W+1:0] s;
		logic signed [P2_W+1:0] v;
		s = ((P2_W+2)'(c) <<< ROOT_FRAC_BITS) + (P2_W+2)'(p)
			+ ((P2_W+2)'(1) <<< (ROOT_FRAC_BITS - 1));
		v = s >>> ROOT_FRAC_BITS;
		if (v > OUT_MAX)
			return OUT_MAX;
		else if (v < OUT_MIN)
			return OUT_MIN;
		else
			return OUT_W'(v);
	endfunction

endpackage

FILE: hdl/quadratic_bezier_scanline_roots.sv
// Top level of the quadratic Bezier scanline root solver.
//
//  channel  dir  payload                                         transfer
//  s_axis   in   p0..p2, sample (8 x 16 bit)                     tvalid & tready
//  m_axis   out  roots, points (6 x 24 bit), status in tuser     tvalid & tready
//
// One curve per cycle is taken and one result per cycle given at full flow.
// The path runs through 2 front stages, the queue, 27 square-root
// stages (one result bit each), 3 set-up stages, 24 divider stages (one
// quotient bit each), 1 saturation stage and 4 evaluation stages.
// Reset clears valid bits, queue pointers and the queue count only.
// A stalled output holds the back end; the queue lets the front keep taking
// transfers until it fills.
module quadratic_bezier_scanline_roots (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, sample_x, sample_y
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// root_plus, root_minus, plus_point_x, plus_point_y, minus_point_x, minus_point_y
	output logic [143:0] m_axis_tdata,
	// status
	output logic [1:0]   m_axis_tuser
);

	logic              f_valid, f_ready, b_valid, b_ready;
	qbsr_pkg::qentry_t f_data, b_data;
	qbsr_pkg::status_t st;

	qbsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data)
	);

	qbsr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	qbsr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (b_valid),
		.q_ready    (b_ready),
		.q_data     (b_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_status (st)
	);

	assign m_axis_tuser = st;

endmodule

FILE: hdl/qbsr_front.sv
// Front end: coefficients, discriminant and classification of each curve.
module qbsr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [8*qbsr_pkg::IN_W-1:0]    in_data,
	output logic                           push_valid,
	input  logic                           push_ready,
	output qbsr_pkg::qentry_t              push_data
);

	localparam int IW = qbsr_pkg::IN_W;
	localparam int AW = qbsr_pkg::A_W;
	localparam int BW = qbsr_pkg::B_W;
	localparam int CW = qbsr_pkg::C_W;
	localparam int FW = qbsr_pkg::DFULL_W;

	logic signed [IW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, smx, smy;
	assign p0x = in_data[1*IW-1:0*IW];
	assign p0y = in_data[2*IW-1:1*IW];
	assign p1x = in_data[3*IW-1:2*IW];
	assign p1y = in_data[4*IW-1:3*IW];
	assign p2x = in_data[5*IW-1:4*IW];
	assign p2y = in_data[6*IW-1:5*IW];
	assign smx = in_data[7*IW-1:6*IW];
	assign smy = in_data[8*IW-1:7*IW];

	qbsr_pkg::coef_t coef_in;
	// the sample point cancels out of a and b
	always_comb begin
		coef_in.ax = AW'(p0x) - (AW'(p1x) <<< 1) + AW'(p2x);
		coef_in.ay = AW'(p0y) - (AW'(p1y) <<< 1) + AW'(p2y);
		coef_in.bx = (BW'(p1x) - BW'(p0x)) <<< 1;
		coef_in.by = (BW'(p1y) - BW'(p0y)) <<< 1;
		coef_in.cx = CW'(p0x) - CW'(smx);
		coef_in.cy = CW'(p0y) - CW'(smy);
	end

	logic                              vld_s1, vld_s2;
	qbsr_pkg::coef_t                   coef_s1, coef_s2;
	logic signed [qbsr_pkg::PROD_W-1:0] bb_s2, ac_s2;
	logic                              en;

	assign en       = !vld_s2 || push_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1 <= coef_in;
			coef_s2 <= coef_s1;
			bb_s2   <= qbsr_pkg::PROD_W'(coef_s1.by * coef_s1.by);
			ac_s2   <= qbsr_pkg::PROD_W'(coef_s1.ay * coef_s1.cy);
		end
	end

	logic signed [FW-1:0] d_full;
	assign d_full = FW'(bb_s2) - (FW'(ac_s2) <<< 2);

	always_comb begin
		push_valid     = vld_s2;
		push_data.coef = coef_s2;
		push_data.d    = d_full[qbsr_pkg::D_W-1:0];
		priority if (d_full < 0) begin
			push_data.status = qbsr_pkg::ST_NEG_DISC;
			push_data.d      = '0;
		end else if (coef_s2.ay == '0) begin
			push_data.status = qbsr_pkg::ST_DEGEN;
		end else begin
			push_data.status = qbsr_pkg::ST_OK;
		end
	end

endmodule

FILE: hdl/qbsr_queue.sv
// Short queue between the front end and the solver back end.
module qbsr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  qbsr_pkg::qentry_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output qbsr_pkg::qentry_t pop_data
);

	localparam int PW = qbsr_pkg::QPTR_W;

	qbsr_pkg::qentry_t mem_q [qbsr_pkg::QDEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       cnt_q;
	logic              push, pop;

	assign push_ready = cnt_q != (PW+1)'(qbsr_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(qbsr_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count missed a pop");

endmodule

FILE: hdl/qbsr_back.sv
// Back end: pipelined square root, root division and curve evaluation.
module qbsr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  qbsr_pkg::qentry_t               q_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [6*qbsr_pkg::OUT_W-1:0]    out_data,
	output qbsr_pkg::status_t               out_status
);

	localparam int SQS  = qbsr_pkg::SQ_STEPS;
	localparam int QW   = qbsr_pkg::Q_W;
	localparam int OW   = qbsr_pkg::OUT_W;
	localparam int NPW  = qbsr_pkg::NP_W;
	localparam int UDW  = qbsr_pkg::UD_W;
	localparam int UNW  = qbsr_pkg::UN_W;
	localparam int DVW  = qbsr_pkg::DIV_W;
	localparam int SQW  = qbsr_pkg::SQ_W;
	localparam int P1W  = qbsr_pkg::P1_W;
	localparam int P2W  = qbsr_pkg::P2_W;
	localparam int INW  = qbsr_pkg::INNER_W;
	localparam int FRB  = qbsr_pkg::ROOT_FRAC_BITS;
	localparam int GRD  = qbsr_pkg::GUARD;

	// stage positions in the valid chain
	localparam int DV0  = SQS + 3;
	localparam int FIN  = DV0 + QW;
	localparam int LAST = FIN + 4;
	localparam int NST  = LAST + 1;

	logic [NST-1:0] vld_q;
	logic           en;

	assign en        = !vld_q[LAST] || out_ready;
	assign q_ready   = en;
	assign out_valid = vld_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NST-2:0], q_valid};
	end

	qbsr_pkg::sq_t   sq_s  [SQS];
	qbsr_pkg::item_t sit_s [SQS];
	qbsr_pkg::sq_t   sq_init;

	assign sq_init.rem = SQW'(q_data.d) << (2 * GRD);
	assign sq_init.res = '0;

	logic signed [NPW-1:0] np_s1 [2];
	logic signed [UDW-1:0] den_s1;
	qbsr_pkg::item_t       it_s1;
	logic [UNW-1:0]        un_s2 [2];
	logic                  neg_s2 [2];
	logic [UDW-1:0]        ud_s2;
	qbsr_pkg::item_t       it_s2;
	qbsr_pkg::dv_t         pr_s3 [2];
	logic [UDW-1:0]        ud_s3;
	qbsr_pkg::item_t       it_s3;

	qbsr_pkg::dv_t         dv_s  [QW][2];
	logic [UDW-1:0]        dud_s [QW];
	qbsr_pkg::item_t       dit_s [QW];

	logic signed [OW-1:0]  t_fin  [2];
	qbsr_pkg::item_t       it_fin;
	logic signed [P1W-1:0] p1_e1  [4];
	logic signed [OW-1:0]  t_e1   [2];
	qbsr_pkg::item_t       it_e1;
	logic signed [INW-1:0] inr_e2 [4];
	logic signed [OW-1:0]  t_e2   [2];
	qbsr_pkg::item_t       it_e2;
	logic signed [P2W-1:0] p2_e3  [4];
	logic signed [OW-1:0]  t_e3   [2];
	qbsr_pkg::item_t       it_e3;
	logic signed [OW-1:0]  out_q  [6];
	qbsr_pkg::status_t     out_status_q;

	logic signed [NPW-1:0] nb_w, s_w;
	assign nb_w = -(NPW'(sit_s[SQS-1].coef.by) <<< GRD);
	assign s_w  = $signed({1'b0, sq_s[SQS-1].res[qbsr_pkg::S_W-1:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			// square root, one bit a stage
			sq_s[0]  <= qbsr_pkg::sq_step(sq_init, 0);
			sit_s[0] <= '{coef: q_data.coef, status: q_data.status};
			for (int k = 1; k < SQS; k++) begin
				sq_s[k]  <= qbsr_pkg::sq_step(sq_s[k-1], k);
				sit_s[k] <= sit_s[k-1];
			end

			// numerators and denominator
			np_s1[0] <= nb_w + s_w;
			np_s1[1] <= nb_w - s_w;
			den_s1   <= UDW'(sit_s[SQS-1].coef.ay) <<< (GRD + 1);
			it_s1    <= sit_s[SQS-1];

			// magnitudes and signs
			for (int l = 0; l < 2; l++) begin
				un_s2[l]  <= np_s1[l][NPW-1] ? UNW'(-np_s1[l]) : UNW'(np_s1[l]);
				neg_s2[l] <= np_s1[l][NPW-1] ^ den_s1[UDW-1];
			end
			ud_s2 <= den_s1[UDW-1] ? UDW'(-den_s1) : UDW'(den_s1);
			it_s2 <= it_s1;

			// scaled dividend with half divisor for rounding; overflow saturates
			for (int l = 0; l < 2; l++) begin
				logic [DVW-1:0] nv;
				logic           ov;
				nv = (DVW'(un_s2[l]) << FRB) + DVW'(ud_s2 >> 1);
				ov = nv >= (DVW'(ud_s2) << QW);
				pr_s3[l].rem <= ov ? '0 : nv;
				pr_s3[l].q   <= '0;
				pr_s3[l].neg <= neg_s2[l];
				pr_s3[l].ovf <= ov;
			end
			ud_s3 <= ud_s2;
			it_s3 <= it_s2;

			// division, one quotient bit a stage
			for (int l = 0; l < 2; l++)
				dv_s[0][l] <= qbsr_pkg::div_step(pr_s3[l], ud_s3, QW - 1);
			dud_s[0] <= ud_s3;
			dit_s[0] <= it_s3;
			for (int j = 1; j < QW; j++) begin
				for (int l = 0; l < 2; l++)
					dv_s[j][l] <= qbsr_pkg::div_step(dv_s[j-1][l], dud_s[j-1], QW - 1 - j);
				dud_s[j] <= dud_s[j-1];
				dit_s[j] <= dit_s[j-1];
			end

			for (int l = 0; l < 2; l++)
				t_fin[l] <= qbsr_pkg::root_sat(dv_s[QW-1][l]);
			it_fin <= dit_s[QW-1];

			// lanes: x at plus, y at plus, x at minus, y at minus
			for (int l = 0; l < 4; l++)
				p1_e1[l] <= P1W'(((l % 2) == 0 ? it_fin.coef.ax : it_fin.coef.ay)
					* t_fin[l / 2]);
			t_e1  <= t_fin;
			it_e1 <= it_fin;

			for (int l = 0; l < 4; l++)
				inr_e2[l] <= qbsr_pkg::eval_inner(
					(l % 2) == 0 ? it_e1.coef.bx : it_e1.coef.by, p1_e1[l]);
			t_e2  <= t_e1;
			it_e2 <= it_e1;

			for (int l = 0; l < 4; l++)
				p2_e3[l] <= P2W'(inr_e2[l] * t_e2[l / 2]);
			t_e3  <= t_e2;
			it_e3 <= it_e2;

			out_status_q <= it_e3.status;
			if (it_e3.status == qbsr_pkg::ST_OK) begin
				out_q[0] <= t_e3[0];
				out_q[1] <= t_e3[1];
				for (int l = 0; l < 4; l++)
					out_q[l+2] <= qbsr_pkg::eval_point(
						(l % 2) == 0 ? it_e3.coef.cx : it_e3.coef.cy, p2_e3[l]);
			end else begin
				for (int l = 0; l < 6; l++)
					out_q[l] <= '0;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 6; l++)
			out_data[l*OW +: OW] = out_q[l];
	end
	assign out_status = out_status_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != qbsr_pkg::ST_OK |-> out_data == '0)
		else $error("failed solve carries non-zero fields");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		en && !q_valid |=> !vld_q[0])
		else $error("pipeline entry without queue transfer");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the quadratic Bezier scanline root solver.
`timescale 1ns / 100ps

module tb_top;

	localparam int  N_RANDOM   = 1600;
	localparam int  WDOG_LIMIT = 20000;
	localparam int  HOLD_LEN   = 400;
	localparam int  HOLD_AT    = 300;
	localparam int  PAUSE_AT   = 900;

	typedef struct {
		logic signed [15:0] c [8];   // p0x p0y p1x p1y p2x p2y sx sy
	} curve_t;

	typedef struct packed {
		logic signed [23:0] mpy;
		logic signed [23:0] mpx;
		logic signed [23:0] ppy;
		logic signed [23:0] ppx;
		logic signed [23:0] tm;
		logic signed [23:0] tp;
		qbsr_pkg::status_t  st;
	} roots_t;

	typedef struct {
		curve_t            cv;
		bit                typed;     // expected result given in the table
		qbsr_pkg::status_t st;        // typed results are all-zero with this status
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	roots_t roots_q [$];
	int     n_fail, n_sent, n_got, n_ok, n_neg, n_degen;
	int     idle_cycles;
	bit     hold_done;

	quadratic_bezier_scanline_roots DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic longint sat_out(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// nearest, ties toward +inf; >>> on longint floors
	function automatic longint rnd16(longint v);
		return (v + (64'sd1 <<< (qbsr_pkg::ROOT_FRAC_BITS - 1))) >>> qbsr_pkg::ROOT_FRAC_BITS;
	endfunction

	function automatic longint int_sqrt(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	// n * 2^16 / den, half away from zero, saturated
	function automatic longint root_quot(longint n, longint den);
		bit        neg;
		bit [63:0] un, ud, q;
		neg = (n < 0) != (den < 0);
		un = (n < 0) ? -n : n;
		ud = (den < 0) ? -den : den;
		q = ((un << qbsr_pkg::ROOT_FRAC_BITS) + ud / 2) / ud;
		if (q > 64'd8388608) q = 64'd8388608;
		return sat_out(neg ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint curve_at(longint q0, longint q1, longint q2, longint t);
		longint ca, cb, inner;
		ca = q0 - 2 * q1 + q2;
		cb = 2 * (q1 - q0);
		inner = rnd16((cb <<< qbsr_pkg::ROOT_FRAC_BITS) + ca * t);
		return sat_out(rnd16((q0 <<< qbsr_pkg::ROOT_FRAC_BITS) + inner * t));
	endfunction

	function automatic roots_t solve_scanline(curve_t cv);
		longint x [3], y [3];
		longint a, b, d, s, nb, den, tp, tm;
		roots_t r;
		for (int k = 0; k < 3; k++) begin
			x[k] = longint'(cv.c[2*k]) - longint'(cv.c[6]);
			y[k] = longint'(cv.c[2*k+1]) - longint'(cv.c[7]);
		end
		a = y[0] - 2 * y[1] + y[2];
		b = 2 * (y[1] - y[0]);
		d = b * b - 4 * a * y[0];
		r = '0;
		if (d < 0) begin
			r.st = qbsr_pkg::ST_NEG_DISC;
			return r;
		end
		if (a == 0) begin
			r.st = qbsr_pkg::ST_DEGEN;
			return r;
		end
		s  = int_sqrt(64'(d) << (2 * qbsr_pkg::GUARD));
		nb = -b * (64'sd1 <<< qbsr_pkg::GUARD);
		den = 2 * a * (64'sd1 <<< qbsr_pkg::GUARD);
		tp = root_quot(nb + s, den);
		tm = root_quot(nb - s, den);
		r.st  = qbsr_pkg::ST_OK;
		r.tp  = tp[23:0];
		r.tm  = tm[23:0];
		r.ppx = 24'(curve_at(x[0], x[1], x[2], tp));
		r.ppy = 24'(curve_at(y[0], y[1], y[2], tp));
		r.mpx = 24'(curve_at(x[0], x[1], x[2], tm));
		r.mpy = 24'(curve_at(y[0], y[1], y[2], tm));
		return r;
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH result %0d %s: got %0d expected %0d", n_got, what, got, want);
		n_fail++;
	endtask

	always @(posedge clk) begin
		roots_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.tp  = m_axis_tdata[23:0];
			got.tm  = m_axis_tdata[47:24];
			got.ppx = m_axis_tdata[71:48];
			got.ppy = m_axis_tdata[95:72];
			got.mpx = m_axis_tdata[119:96];
			got.mpy = m_axis_tdata[143:120];
			got.st  = qbsr_pkg::status_t'(m_axis_tuser);
			if (roots_q.size() == 0) begin
				$display("MISMATCH unexpected transfer on the output");
				n_fail++;
			end else begin
				want = roots_q.pop_front();
				if (got.st != want.st) report_mismatch("status", got.st, want.st);
				if (got.tp != want.tp) report_mismatch("root_plus", got.tp, want.tp);
				if (got.tm != want.tm) report_mismatch("root_minus", got.tm, want.tm);
				if (got.ppx != want.ppx) report_mismatch("plus_point_x", got.ppx, want.ppx);
				if (got.ppy != want.ppy) report_mismatch("plus_point_y", got.ppy, want.ppy);
				if (got.mpx != want.mpx) report_mismatch("minus_point_x", got.mpx, want.mpx);
				if (got.mpy != want.mpy) report_mismatch("minus_point_y", got.mpy, want.mpy);
				case (want.st)
					qbsr_pkg::ST_OK:       n_ok++;
					qbsr_pkg::ST_NEG_DISC: n_neg++;
					default:               n_degen++;
				endcase
			end
			n_got++;
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", WDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic row_t mk_row(int p0x, int p0y, int p1x, int p1y, int p2x,
			int p2y, int sx, int sy, bit typed, qbsr_pkg::status_t st);
		row_t r;
		r.cv.c = '{16'(p0x), 16'(p0y), 16'(p1x), 16'(p1y), 16'(p2x), 16'(p2y),
			16'(sx), 16'(sy)};
		r.typed = typed;
		r.st = st;
		return r;
	endfunction

	function automatic curve_t rand_curve();
		curve_t cv;
		int mode;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < 8; k++)
			cv.c[k] = (mode < 5) ? 16'($urandom) : 16'($signed($urandom_range(0, 4095)) - 2048);
		if (mode == 8)      // straight in y: leading coefficient zero
			cv.c[5] = 16'(2 * int'(cv.c[3]) - int'(cv.c[1]));
		else if (mode == 9) // curve starts on the scanline
			cv.c[7] = cv.c[1];
		return cv;
	endfunction

	task automatic send_curve(curve_t cv, bit typed, qbsr_pkg::status_t st);
		roots_t       want;
		logic [127:0] bus;
		for (int k = 0; k < 8; k++) bus[16*k +: 16] = cv.c[k];
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= bus;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (typed) begin
			want = '0;
			want.st = st;
		end else
			want = solve_scanline(cv);
		roots_q.push_back(want);
		n_sent++;
	endtask

	task automatic gap_after();
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// receiver side: random stalls, one long hold-off
	initial begin
		int g;
		m_axis_tready = 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && n_sent >= HOLD_AT) begin
				hold_done = 1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				g = gap_len();
				if (g > 0) begin
					m_axis_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(0, 20)) @(posedge clk);
		end
	end

	initial begin
		row_t dir [$];
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		n_fail = 0; n_sent = 0; n_got = 0;
		n_ok = 0; n_neg = 0; n_degen = 0;
		idle_cycles = 0;

		// all zero: flat on the line
		dir.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 1, qbsr_pkg::ST_DEGEN));
		// y = 2t^2 - 2t + 1 has no real root
		dir.push_back(mk_row(0, 1, 0, 0, 0, 1, 0, 0, 1, qbsr_pkg::ST_NEG_DISC));
		// straight line in y
		dir.push_back(mk_row(5, -100, 7, 0, 9, 100, 0, 0, 1, qbsr_pkg::ST_DEGEN));
		dir.push_back(mk_row(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768,
			1, qbsr_pkg::ST_DEGEN));
		dir.push_back(mk_row(-32768, 32767, 32767, -32768, -32768, 32767, 0, 0, 0,
			qbsr_pkg::ST_OK));
		dir.push_back(mk_row(32767, -32768, -32768, 32767, 32767, -32768, 0, 0, 0,
			qbsr_pkg::ST_OK));
		dir.push_back(mk_row(32767, 32767, -32768, -32768, 32767, 32767, -32768, 32767,
			0, qbsr_pkg::ST_OK));
		dir.push_back(mk_row(-32768, -32768, 32767, 32767, -32768, -32768, 32767, -32768,
			0, qbsr_pkg::ST_OK));
		// double root at t = 0, tiny leading coefficient
		dir.push_back(mk_row(0, 0, 16384, 0, 0, 1, 0, 0, 0, qbsr_pkg::ST_OK));
		dir.push_back(mk_row(0, -1, 0, 0, 0, 0, 0, 0, 0, qbsr_pkg::ST_OK));
		dir.push_back(mk_row(0, -16384, 8192, 16384, 16384, -16384, 0, 0, 0,
			qbsr_pkg::ST_OK));
		dir.push_back(mk_row(100, 16384, -100, -16384, 300, 16384, 50, 0, 0,
			qbsr_pkg::ST_OK));
		dir.push_back(mk_row(-1, -1, -1, -1, -1, -1, -1, -1, 1, qbsr_pkg::ST_DEGEN));
		dir.push_back(mk_row(16384, 8192, -16384, -8192, 16384, 8192, 0, 4096, 0,
			qbsr_pkg::ST_OK));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			send_curve(dir[i].cv, dir[i].typed, dir[i].st);
			gap_after();
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			send_curve(rand_curve(), 0, qbsr_pkg::ST_OK);
			if (i == PAUSE_AT) begin
				s_axis_tvalid <= 1'b0;
				while (roots_q.size() != 0) @(posedge clk);
			end else if (i > 1200 && i < 1400)
				;   // a run at full flow on the input
			else
				gap_after();
		end
		s_axis_tvalid <= 1'b0;

		while (roots_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d curves (%0d directed), checked %0d results", n_sent, dir.size(),
			n_got);
		$display("Status mix: %0d ok, %0d negative discriminant, %0d degenerate", n_ok,
			n_neg, n_degen);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
